[rtl/ring_buffer_deque_macros.svh]
// Assertion macros for the ring buffer deque.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rbd_pkg.sv]
// Shared types and constants of the ring buffer deque.
// No dependencies; imported by ring_buffer_deque.
package rbd_pkg;

   localparam int REQ_W  = 3;
   localparam int IDX_W  = 6;
   localparam int CAP_W  = 7;
   localparam int CNT_W  = 7;
   localparam int STAT_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [REQ_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ       = 3'd4
   } req_op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

[rtl/ring_buffer_deque.sv]
// Ring buffer deque: push/pop at either end and indexed read over a slot memory.
// Depends on rbd_pkg and ring_buffer_deque_macros.svh.
//
//   channel | direction | handshake          | content
//   --------+-----------+--------------------+-----------------------------------
//   req_    | in        | req_valid/req_stall | request type, push value, index
//   rsp_    | out       | rsp_valid/rsp_stall | status, read data, ends, count
//   csr_    | in        | csr_valid/csr_ready | capacity in use
//
// Push, pop, unknown and out-of-range read requests step through S_RD and S_DONE; a read
// in range steps through S_RD, one S_MOD pass per capacity subtraction of head + index
// (one when the index runs past the ring end, more only after capacity has been lowered
// below the count), S_RDX and S_DONE. Items follow with no gap while the result register
// drains; a stalled result holds. After a capacity write, head and tail are reduced by one
// subtraction per cycle before the next item is taken. Reset is synchronous: pointers and
// count clear, capacity returns to 64, slot contents stay undefined until written.
`include "ring_buffer_deque_macros.svh"

module ring_buffer_deque #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rbd_pkg::REQ_W-1:0]  req_type,
   input  logic [WIDTH-1:0]           req_push_value,
   input  logic [rbd_pkg::IDX_W-1:0]  req_logical_index,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rbd_pkg::STAT_W-1:0] rsp_status,
   output logic [WIDTH-1:0]           rsp_read_data,
   output logic [WIDTH-1:0]           rsp_front_value,
   output logic [WIDTH-1:0]           rsp_back_value,
   output logic [rbd_pkg::CNT_W-1:0]  rsp_element_count,
   output logic                       rsp_is_empty,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [rbd_pkg::CAP_W-1:0]  csr_capacity_in_use
);
   import rbd_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int PW = ((AW + 1) > CAP_W) ? (AW + 1) : CAP_W;
   localparam int SW = PW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_MOD,
      S_RDX,
      S_DONE
   } state_type;

   logic [WIDTH-1:0] slot_mem [DEPTH];

   state_type         state_ff,  state_in;
   logic [AW-1:0]     head_ff,   head_in;
   logic [AW-1:0]     tail_ff,   tail_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic [CAP_W-1:0]  cap_ff,    cap_in;
   req_op_type        op_ff,     op_in;
   status_type        status_ff, status_in;
   logic [SW-1:0]     sum_ff,    sum_in;
   logic              rsp_valid_ff,  rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [WIDTH-1:0]  rsp_read_ff,   rsp_read_in;
   logic [WIDTH-1:0]  rsp_front_ff,  rsp_front_in;
   logic [WIDTH-1:0]  rsp_back_ff,   rsp_back_in;
   logic [CNT_W-1:0]  rsp_count_ff,  rsp_count_in;
   logic              rsp_empty_ff,  rsp_empty_in;

   logic [WIDTH-1:0]  front_rd_ff;
   logic [WIDTH-1:0]  back_rd_ff;
   logic [WIDTH-1:0]  index_rd_ff;

   logic [PW-1:0]     ecap;
   logic [PW-1:0]     head_x;
   logic [PW-1:0]     tail_x;
   logic [PW-1:0]     count_x;
   logic [SW-1:0]     sum_red;
   logic              pos_ok;
   logic              out_free;
   logic              accept;
   logic              load_rsp;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd0_addr;
   logic [AW-1:0]     back_addr;
   req_op_type        req_op;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] x,
                                              input logic [PW-1:0] c);
      logic [PW-1:0] nx;
      nx = x + PW'(1);
      return (nx == c) ? '0 : nx;
   endfunction

   function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] x,
                                              input logic [PW-1:0] c);
      return (x == '0) ? (c - PW'(1)) : (x - PW'(1));
   endfunction

   always_comb begin
      ecap = PW'(cap_ff);
      if (cap_ff == '0) begin
         ecap = PW'(1);
      end else if (PW'(cap_ff) > PW'(DEPTH)) begin
         ecap = PW'(DEPTH);
      end
   end

   assign head_x    = PW'(head_ff);
   assign tail_x    = PW'(tail_ff);
   assign count_x   = PW'(count_ff);
   assign pos_ok    = (head_x < ecap) && (tail_x < ecap);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == S_DONE) && out_free;
   assign req_stall = !(pos_ok && ((state_ff == S_IDLE) || load_rsp));
   assign accept    = req_valid && !req_stall;
   assign req_op    = req_op_type'(req_type);
   assign sum_red   = sum_ff - SW'(ecap);
   assign back_addr = AW'(wrap_dec(tail_x, ecap));
   assign rd0_addr  = (state_ff == S_RDX) ? AW'(sum_ff) : head_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = tail_ff;

      if (csr_valid) begin
         cap_in = csr_capacity_in_use;
      end

      unique case (state_ff)
         S_IDLE: begin
         end
         S_RD: begin
            if ((op_ff == OP_READ) && (status_ff == ST_OK)) begin
               state_in = (sum_ff >= SW'(ecap)) ? S_MOD : S_RDX;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MOD: begin
            sum_in = sum_red;
            if (sum_red < SW'(ecap)) begin
               state_in = S_RDX;
            end
         end
         S_RDX: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // drain or refill the result register
      if (load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_read_in   = ((op_ff == OP_READ) && (status_ff == ST_OK)) ? index_rd_ff : '0;
         rsp_front_in  = (count_ff == '0) ? '0 : front_rd_ff;
         rsp_back_in   = (count_ff == '0) ? '0 : back_rd_ff;
         rsp_count_in  = count_ff;
         rsp_empty_in  = (count_ff == '0);
      end else if (!rsp_stall) begin
         rsp_valid_in  = 1'b0;
      end

      if (accept) begin
         state_in  = S_RD;
         op_in     = req_op;
         status_in = ST_OK;
         sum_in    = SW'(head_x) + SW'(req_logical_index);
         unique case (req_op)
            OP_PUSH_BACK: begin
               if (count_x >= ecap) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = tail_ff;
                  tail_in  = AW'(wrap_inc(tail_x, ecap));
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_PUSH_FRONT: begin
               if (count_x >= ecap) begin
                  status_in = ST_FULL;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = AW'(wrap_dec(head_x, ecap));
                  head_in  = AW'(wrap_dec(head_x, ecap));
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_POP_BACK: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  tail_in  = AW'(wrap_dec(tail_x, ecap));
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_POP_FRONT: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  head_in  = AW'(wrap_inc(head_x, ecap));
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_READ: begin
               if (CNT_W'(req_logical_index) >= count_ff) begin
                  status_in = ST_RANGE;
               end
            end
            default: begin
            end
         endcase
      end else if (!pos_ok) begin
         // fold head and tail back under a lowered capacity
         if (head_x >= ecap) begin
            head_in = AW'(head_x - ecap);
         end
         if (tail_x >= ecap) begin
            tail_in = AW'(tail_x - ecap);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      status_ff     <= status_in;
      sum_ff        <= sum_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RD) begin
         front_rd_ff <= slot_mem[rd0_addr];
         back_rd_ff  <= slot_mem[back_addr];
      end
      if (state_ff == S_RDX) begin
         index_rd_ff <= slot_mem[rd0_addr];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_data     = rsp_read_ff;
   assign rsp_front_value   = rsp_front_ff;
   assign rsp_back_value    = rsp_back_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_is_empty      = rsp_empty_ff;

   `RBD_ASSERT_SAME(a_accept_pos_ok, clock, reset, accept, (head_x < ecap) && (tail_x < ecap), "item taken with head or tail beyond capacity")
   `RBD_ASSERT_SAME(a_index_in_range, clock, reset, state_ff == S_RDX, sum_ff < SW'(ecap), "indexed read address not reduced below capacity")
   `RBD_ASSERT_SAME(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_DONE), "result raised outside the finishing state")
   `RBD_ASSERT_NEXT(a_push_counts, clock, reset, accept && (req_op == OP_PUSH_BACK || req_op == OP_PUSH_FRONT) && (count_x < ecap), count_ff == $past(count_ff) + CNT_W'(1), "accepted push did not advance the count")
   `RBD_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, PW'(count_ff) <= PW'(DEPTH), "element count beyond memory depth")

endmodule
